@@ design/tbp_pkg.sv @@
// Shared widths, status codes and pipeline tag type for the triangular partition block.
`default_nettype none
package tbp_pkg;
  localparam int ROW_BITS  = 16;
  localparam int PART_BITS = 10;
  localparam int KW        = PART_BITS + 1;
  localparam int TW        = 2 * ROW_BITS;
  localparam int VW        = TW + KW + 3;
  localparam int QW        = (VW + 1) / 2;
  localparam int RW        = PART_BITS + 2;
  localparam int CNT_W     = $clog2(TW + 1);
  localparam int CFG_DW    = (ROW_BITS > KW) ? ROW_BITS : KW;
  localparam int CFG_AW    = 8;

  localparam logic [CFG_AW-1:0] REG_MATRIX_ROWS = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_PART_COUNT  = CFG_AW'(1);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FEW     = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_BAD_IDX = 2'd3;

  typedef struct packed {
    logic                 valid;
    logic [PART_BITS-1:0] idx;
    logic [1:0]           status;
  } tag_t;
endpackage
`default_nettype wire

@@ design/tbp_div.sv @@
// Element total and ceiling share per part, computed bit-serially after each register write.
`default_nettype none
module tbp_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [tbp_pkg::ROW_BITS-1:0] n,
  input  wire logic [tbp_pkg::KW-1:0]       p,
  output logic      [tbp_pkg::TW-1:0]       share,
  output logic                              few,
  output logic                              busy
);
  import tbp_pkg::*;

  logic              ld_r, fin_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TW-1:0]     q_r, s_r;
  logic [RW-1:0]     rem_r, rsh;
  logic              few_r;
  logic [TW:0]       prod;
  logic [TW-1:0]     tval;
  logic [TW+KW-1:0]  t_ext, p_ext;

  assign prod  = (TW+1)'(n) * ((TW+1)'(n) + (TW+1)'(1));
  assign tval  = prod[TW:1];
  assign t_ext = (TW+KW)'(tval);
  assign p_ext = (TW+KW)'(p);
  assign rsh   = {rem_r[RW-2:0], q_r[TW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r  <= 1'b1;
      fin_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      ld_r  <= 1'b1;
      fin_r <= 1'b0;
      cnt_r <= '0;
    end else if (ld_r) begin
      ld_r  <= 1'b0;
      cnt_r <= CNT_W'(TW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
      fin_r <= (cnt_r == CNT_W'(1));
    end else begin
      fin_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_r) begin
      q_r   <= tval;
      rem_r <= '0;
      few_r <= t_ext < p_ext;
    end else if (cnt_r != '0) begin
      if (rsh >= RW'(p)) begin
        rem_r <= rsh - RW'(p);
        q_r   <= {q_r[TW-2:0], 1'b1};
      end else begin
        rem_r <= rsh;
        q_r   <= {q_r[TW-2:0], 1'b0};
      end
    end else if (fin_r) begin
      s_r <= q_r + TW'(rem_r != '0);
    end
  end

  assign share = s_r;
  assign few   = few_r;
  assign busy  = ld_r || fin_r || (cnt_r != '0);
endmodule
`default_nettype wire

@@ design/tbp_root.sv @@
// Pipelined exact integer square root, one root bit per stage, two lanes sharing one tag.
`default_nettype none
module tbp_root (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire tbp_pkg::tag_t          in_tag,
  input  wire logic [tbp_pkg::VW-1:0] in_v0,
  input  wire logic [tbp_pkg::VW-1:0] in_v1,
  output tbp_pkg::tag_t               out_tag,
  output logic      [tbp_pkg::QW-1:0] out_q0,
  output logic      [tbp_pkg::QW-1:0] out_q1
);
  import tbp_pkg::*;

  tag_t          tag_r  [QW];
  logic [VW-1:0] rem_r  [QW][2];
  logic [QW-1:0] root_r [QW][2];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    tag_t tag_prev;
    assign tag_prev = (s == 0) ? in_tag : tag_r[(s == 0) ? 0 : s - 1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[s].valid <= 1'b0;
      end else if (en) begin
        tag_r[s] <= tag_prev;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [VW-1:0]   rem_prev;
      logic [QW-1:0]   root_prev;
      logic [VW+1:0]   trial;
      if (s == 0) begin : g_first
        assign rem_prev  = (l == 0) ? in_v0 : in_v1;
        assign root_prev = '0;
      end else begin : g_next
        assign rem_prev  = rem_r[s-1][l];
        assign root_prev = root_r[s-1][l];
      end
      assign trial = ((VW+2)'(root_prev) << (B + 1)) + ((VW+2)'(1) << (2 * B));

      always_ff @(posedge clk) begin
        if (en) begin
          if ((VW+2)'(rem_prev) >= trial) begin
            rem_r[s][l]  <= rem_prev - trial[VW-1:0];
            root_r[s][l] <= root_prev | (QW'(1) << B);
          end else begin
            rem_r[s][l]  <= rem_prev;
            root_r[s][l] <= root_prev;
          end
        end
      end
    end
  end

  assign out_tag = tag_r[QW-1];
  assign out_q0  = root_r[QW-1][0];
  assign out_q1  = root_r[QW-1][1];
endmodule
`default_nettype wire

@@ design/triangular_balanced_partition.sv @@
// Top level of the load-balanced row partition of a lower-triangular matrix.
// Usage:
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
// register 0, the row count n, and register 1, the part count P. cfg_ready is
// always high. After each write, and after reset, the share per part is
// recomputed by a bit-serial divider, during which in_stall is
// high. Reset sets n = 1 and P = 1 and empties the pipeline.
// A query transfer on in_ carries part_index; each one gives exactly one
// result transfer on out_ with first_row, row_count and status.
// Input transfer to output valid passes one stage for the multiplications,
// one stage per root bit of the square root pipeline (23), and one output
// register. One item is accepted per cycle while in_stall is low.
// When the receiver asserts out_stall with a result pending, the whole
// pipeline holds and in_stall rises in the same cycle; nothing is lost.
`default_nettype none
module triangular_balanced_partition (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [tbp_pkg::PART_BITS-1:0]  in_part_index,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [tbp_pkg::ROW_BITS-1:0]   out_first_row,
  output logic      [tbp_pkg::ROW_BITS-1:0]   out_row_count,
  output logic      [1:0]                     out_status,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tbp_pkg::CFG_AW-1:0]     cfg_index,
  input  wire logic [tbp_pkg::CFG_DW-1:0]     cfg_data
);
  import tbp_pkg::*;

  logic [ROW_BITS-1:0] n_r;
  logic [KW-1:0]       p_r;
  logic                cfg_wr, busy, few, en, accept;
  logic [TW-1:0]       share;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= ROW_BITS'(1);
      p_r <= KW'(1);
    end else if (cfg_wr) begin
      if (cfg_index == REG_MATRIX_ROWS) n_r <= cfg_data[ROW_BITS-1:0];
      else if (cfg_index == REG_PART_COUNT) p_r <= cfg_data[KW-1:0];
    end
  end

  tbp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cfg_wr), .n(n_r), .p(p_r),
    .share(share), .few(few), .busy(busy)
  );

  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = busy || !en;
  assign accept   = in_valid && !in_stall;

  tag_t            tag0_r, tag_in, tag_out;
  logic [VW-1:0]   v0_r, v1_r;
  logic [KW+TW-1:0] ks0, ks1;

  assign ks0 = (KW+TW)'(in_part_index) * (KW+TW)'(share);
  assign ks1 = ((KW+TW)'(in_part_index) + (KW+TW)'(1)) * (KW+TW)'(share);

  always_comb begin
    tag_in.valid = accept;
    tag_in.idx   = in_part_index;
    if (few) tag_in.status = ST_FEW;
    else if (KW'(in_part_index) >= p_r) tag_in.status = ST_BAD_IDX;
    else tag_in.status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag0_r.valid <= 1'b0;
    end else if (en) begin
      tag0_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v0_r <= (VW'(ks0) << 3) + VW'(1);
      v1_r <= (VW'(ks1) << 3) + VW'(1);
    end
  end

  logic [QW-1:0] q0, q1, rb0, rb1, beg, fin, n_ext;
  tbp_root u_root (
    .clk(clk), .rst_n(rst_n), .en(en), .in_tag(tag0_r),
    .in_v0(v0_r), .in_v1(v1_r), .out_tag(tag_out), .out_q0(q0), .out_q1(q1)
  );

  logic [1:0]          st;
  logic [ROW_BITS-1:0] first_nxt, count_nxt;
  logic                first_part, last_part;

  assign n_ext      = QW'(n_r);
  assign rb0        = (q0 - QW'(1)) >> 1;
  assign rb1        = (q1 - QW'(1)) >> 1;
  assign first_part = (tag_out.idx == '0);
  assign last_part  = (KW'(tag_out.idx) == p_r - KW'(1));

  always_comb begin
    beg = first_part ? '0 : rb0;
    fin = rb1;
    if (first_part && p_r <= KW'(1)) fin = n_ext;
    if (n_r > ROW_BITS'(1) && last_part) fin = n_ext;
    first_nxt = '0;
    count_nxt = '0;
    st        = tag_out.status;
    if (st == ST_OK) begin
      if (beg >= fin || fin > n_ext) begin
        st = ST_RANGE;
      end else begin
        first_nxt = beg[ROW_BITS-1:0];
        count_nxt = ROW_BITS'(fin - beg);
      end
    end
  end

  logic [ROW_BITS-1:0] first_r, count_r;
  logic [1:0]          status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tag_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      first_r  <= first_nxt;
      count_r  <= count_nxt;
      status_r <= st;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_first_row = first_r;
  assign out_row_count = count_r;
  assign out_status    = status_r;
endmodule
`default_nettype wire
